// ----- rtl/kbw_pkg.sv -----
`default_nettype none

package kbw_pkg;

    localparam int POS_W      = 32;
    localparam int WIDTH_W    = 31;
    localparam int VALUE_W    = 31;
    localparam int FRAC_BITS  = 30;
    localparam int ACC_W      = FRAC_BITS + 2;
    localparam int DEN_W      = 2 * WIDTH_W;
    localparam int PROD_W     = ACC_W + FRAC_BITS;
    localparam int TABLE_BITS = 40;
    localparam int TABLE_LEN  = 13;
    localparam int TBL_IDX_W  = $clog2(TABLE_LEN);
    localparam int COEF_SHIFT = TABLE_BITS - FRAC_BITS;
    localparam int COEFF_COUNT = 13;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_WIDTH = '0;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(65536);
    localparam logic [ACC_W-1:0]   ONE         = ACC_W'(1) << FRAC_BITS;
    localparam logic [PROD_W:0]    HALF        = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    // c_k * 2^40
    localparam logic [TABLE_BITS-1:0] COEF_TBL [0:TABLE_LEN-1] = '{
        40'd151493773,
        40'd4578999812,
        40'd34600826844,
        40'd116203660918,
        40'd219520796867,
        40'd265406469304,
        40'd222835739615,
        40'd137456287277,
        40'd64917304409,
        40'd24224303667,
        40'd7321956506,
        40'd1829016474,
        40'd383911364
    };

    typedef struct packed {
        logic [VALUE_W-1:0] window_value;
        logic               in_window;
    } t_result;

    // coefficient rounded half up to FRAC_BITS fraction bits
    function automatic logic [ACC_W-1:0] coeff(input int k);
        logic [TABLE_BITS:0] t;
        t = {1'b0, COEF_TBL[TBL_IDX_W'(k)]} + ((TABLE_BITS + 1)'(1) << (COEF_SHIFT - 1));
        return ACC_W'(t >> COEF_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kbw_if.sv -----
`default_nettype none

interface kbw_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [kbw_pkg::POS_W-1:0]    position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

interface kbw_out_if;
    logic                                valid;
    logic                                ready;
    logic        [kbw_pkg::VALUE_W-1:0]  window_value;
    logic                                in_window;

    modport source (output valid, output window_value, output in_window, input ready);
    modport sink   (input valid, input window_value, input in_window, output ready);
endinterface

`default_nettype wire

// ----- rtl/kaiser_bessel_window_eval.sv -----
// throughput: one word per cycle while no skid word is held;
// restoring divider has one quotient bit per stage,
// each horner step is a multiply stage followed by a round-and-add stage
// output register plus skid word; input ready drops only while the skid word is held
// synchronous active-low reset clears all valid bits and sets window_width to 1.0
`default_nettype none

module kaiser_bessel_window_eval #(
    parameter int COEFF_COUNT = kbw_pkg::COEFF_COUNT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    kbw_in_if.sink                           i_in,
    kbw_out_if.source                        o_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [kbw_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [kbw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [kbw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int F     = kbw_pkg::FRAC_BITS;
    localparam int N     = (COEFF_COUNT > kbw_pkg::TABLE_LEN) ? kbw_pkg::TABLE_LEN :
                           (COEFF_COUNT < 1) ? 1 : COEFF_COUNT;
    localparam int NSTEP = N - 1;
    localparam int NM    = (NSTEP > 0) ? NSTEP : 1;
    localparam int AW    = kbw_pkg::ACC_W;
    localparam int DW    = kbw_pkg::DEN_W;
    localparam int PW    = kbw_pkg::PROD_W;
    localparam int WW    = kbw_pkg::WIDTH_W;

    // config register
    logic [WW-1:0]               r_width;
    logic [DW-1:0]               r_den;
    logic [kbw_pkg::REG_IDX_W-1:0] reg_idx;
    logic                        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[kbw_pkg::APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && (reg_idx == kbw_pkg::REG_WINDOW_WIDTH);
    assign prdata  = (reg_idx == kbw_pkg::REG_WINDOW_WIDTH) ?
                     kbw_pkg::APB_DATA_W'(r_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= kbw_pkg::WIDTH_RESET;
        end else if (cfg_wr) begin
            r_width <= pwdata[WW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= DW'(r_width) * DW'(r_width);
    end

    logic en;

    // front stages
    logic                        r_s1_vld, r_s2_vld, r_s3_vld;
    logic [kbw_pkg::POS_W-1:0]   r_s1_pos;
    logic [WW-1:0]               r_s2_twox;
    logic                        r_s2_in, r_s3_in;
    logic [DW-1:0]               r_s3_sq;
    logic [kbw_pkg::POS_W-1:0]   ax;
    logic [kbw_pkg::POS_W:0]     twox;

    assign ax   = r_s1_pos[kbw_pkg::POS_W-1] ? (~r_s1_pos + 1'b1) : r_s1_pos;
    assign twox = {ax, 1'b0};

    // divider stages, index 0 holds the numerator
    logic          r_d_vld [0:F];
    logic          r_d_in  [0:F];
    logic [DW-1:0] r_d_rem [0:F];
    logic [F-1:0]  r_d_q   [0:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_d_vld[0]  <= 1'b0;
        end else if (en) begin
            r_s1_vld    <= i_in.valid;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_d_vld[0]  <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pos   <= i_in.position;
            r_s2_in    <= (twox < (kbw_pkg::POS_W + 1)'(r_width));
            r_s2_twox  <= twox[WW-1:0];
            r_s3_in    <= r_s2_in;
            r_s3_sq    <= DW'(r_s2_twox) * DW'(r_s2_twox);
            r_d_in[0]  <= r_s3_in;
            r_d_rem[0] <= r_den - r_s3_sq;
            r_d_q[0]   <= '0;
        end
    end

    for (genvar i = 1; i <= F; i++) begin : g_div
        logic [DW:0] sh;
        logic        ge;
        assign sh = {r_d_rem[i-1], 1'b0};
        assign ge = (sh >= {1'b0, r_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[i] <= 1'b0;
            end else if (en) begin
                r_d_vld[i] <= r_d_vld[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d_in[i]  <= r_d_in[i-1];
                r_d_rem[i] <= ge ? DW'(sh - {1'b0, r_den}) : sh[DW-1:0];
                r_d_q[i]   <= {r_d_q[i-1][F-2:0], ge};
            end
        end
    end

    // horner steps: multiply stage then round-and-add stage
    logic          r_m_vld  [0:NM-1];
    logic          r_m_in   [0:NM-1];
    logic [PW-1:0] r_m_prod [0:NM-1];
    logic [F-1:0]  r_m_q    [0:NM-1];
    logic          r_a_vld  [0:NM-1];
    logic          r_a_in   [0:NM-1];
    logic [AW-1:0] r_a_acc  [0:NM-1];
    logic [F-1:0]  r_a_q    [0:NM-1];

    for (genvar j = 0; j < NSTEP; j++) begin : g_horner
        logic          src_vld;
        logic          src_in;
        logic [AW-1:0] src_acc;
        logic [F-1:0]  src_q;
        logic [PW:0]   rnd;

        if (j == 0) begin : g_first
            assign src_vld = r_d_vld[F];
            assign src_in  = r_d_in[F];
            assign src_acc = kbw_pkg::coeff(N - 1);
            assign src_q   = r_d_q[F];
        end else begin : g_next
            assign src_vld = r_a_vld[j-1];
            assign src_in  = r_a_in[j-1];
            assign src_acc = r_a_acc[j-1];
            assign src_q   = r_a_q[j-1];
        end

        assign rnd = {1'b0, r_m_prod[j]} + kbw_pkg::HALF;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_vld[j] <= 1'b0;
                r_a_vld[j] <= 1'b0;
            end else if (en) begin
                r_m_vld[j] <= src_vld;
                r_a_vld[j] <= r_m_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m_in[j]   <= src_in;
                r_m_q[j]    <= src_q;
                r_m_prod[j] <= PW'(src_acc) * PW'(src_q);
                r_a_in[j]   <= r_m_in[j];
                r_a_q[j]    <= r_m_q[j];
                r_a_acc[j]  <= AW'(rnd >> F) + kbw_pkg::coeff(N - 2 - j);
            end
        end
    end

    logic          p_vld;
    logic          p_in;
    logic [AW-1:0] p_acc;

    if (NSTEP > 0) begin : g_tail_horner
        assign p_vld = r_a_vld[NSTEP-1];
        assign p_in  = r_a_in[NSTEP-1];
        assign p_acc = r_a_acc[NSTEP-1];
    end else begin : g_tail_const
        assign p_vld = r_d_vld[F];
        assign p_in  = r_d_in[F];
        assign p_acc = kbw_pkg::coeff(0);
    end

    kbw_pkg::t_result p_res;

    always_comb begin
        p_res.in_window = p_in;
        if (!p_in) begin
            p_res.window_value = '0;
        end else if (p_acc > kbw_pkg::ONE) begin
            p_res.window_value = kbw_pkg::VALUE_W'(kbw_pkg::ONE);
        end else begin
            p_res.window_value = p_acc[kbw_pkg::VALUE_W-1:0];
        end
    end

    // output register and skid word
    logic             r_out_vld;
    logic             r_skid_vld;
    kbw_pkg::t_result r_out;
    kbw_pkg::t_result r_skid;

    assign en          = !r_skid_vld;
    assign i_in.ready  = en;

    assign o_out.valid        = r_out_vld;
    assign o_out.window_value = r_out.window_value;
    assign o_out.in_window    = r_out.in_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_out.ready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || o_out.ready) begin
            r_out_vld <= p_vld;
        end else if (p_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (o_out.ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || o_out.ready) begin
            r_out <= p_res;
        end else begin
            r_skid <= p_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held without an output word");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(o_out.valid && !o_out.ready && p_vld))
        else $error("skid word loaded without a stalled output");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.in_window) |-> (o_out.window_value == '0))
        else $error("nonzero value outside the window");

    a_value_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.window_value <= kbw_pkg::VALUE_W'(kbw_pkg::ONE)))
        else $error("window value above one");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !o_out.ready) |=> ($stable(r_skid) && r_skid_vld))
        else $error("skid word lost during stall");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_kaiser_bessel_window_eval.sv -----
`timescale 1ns / 1ps

module tb_kaiser_bessel_window_eval;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 80;
    localparam int GAP_PCT      = 34;
    localparam int TAP_BITS     = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [kbw_pkg::APB_ADDR_W-1:0] WIDTH_ADDR = {kbw_pkg::REG_WINDOW_WIDTH, 2'b00};
    localparam logic [kbw_pkg::WIDTH_W-1:0]    WIDTH_MAX  = '1;

    // taylor coefficients scaled by 2^40
    localparam logic [TAP_BITS-1:0] TAPS_Q40 [0:12] = '{
        40'd151493773,
        40'd4578999812,
        40'd34600826844,
        40'd116203660918,
        40'd219520796867,
        40'd265406469304,
        40'd222835739615,
        40'd137456287277,
        40'd64917304409,
        40'd24224303667,
        40'd7321956506,
        40'd1829016474,
        40'd383911364
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [kbw_pkg::APB_ADDR_W-1:0] paddr;
    logic [kbw_pkg::APB_DATA_W-1:0] pwdata;
    logic [kbw_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    kbw_in_if  in_if ();
    kbw_out_if out_if ();

    kbw_pkg::t_result              expected_windows [$];
    kbw_pkg::t_result              oldest_window;
    logic [kbw_pkg::WIDTH_W-1:0]   width_now;
    int unsigned                   fail_count = 0;
    int unsigned                   cycle_count = 0;
    bit                            source_gaps_on;
    bit                            sink_gaps_on;
    bit                            sink_hold;

    kaiser_bessel_window_eval i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [kbw_pkg::ACC_W-1:0] tap_q30(input int k);
        return kbw_pkg::ACC_W'((64'(TAPS_Q40[kbw_pkg::TBL_IDX_W'(k)])
                               + (64'd1 << (TAP_BITS - kbw_pkg::FRAC_BITS - 1)))
                               >> (TAP_BITS - kbw_pkg::FRAC_BITS));
    endfunction

    function automatic kbw_pkg::t_result window_of(
        input logic signed [kbw_pkg::POS_W-1:0] pos,
        input logic [kbw_pkg::WIDTH_W-1:0] width);
        logic [32:0]      mag;
        logic [33:0]      twice;
        logic [127:0]     den;
        logic [127:0]     num;
        logic [127:0]     u;
        logic [127:0]     acc;
        kbw_pkg::t_result r;
        r = '0;
        mag = pos[kbw_pkg::POS_W-1] ? 33'h1_0000_0000 - {1'b0, pos} : {1'b0, pos};
        twice = {mag, 1'b0};
        if (twice >= 34'(width)) return r;
        den = 128'(width) * 128'(width);
        num = den - 128'(twice) * 128'(twice);
        u = (num << kbw_pkg::FRAC_BITS) / den;
        // at the center the divider gives all ones rather than 1.0
        if (u >= (128'd1 << kbw_pkg::FRAC_BITS)) u = (128'd1 << kbw_pkg::FRAC_BITS) - 1;
        acc = 128'(tap_q30(kbw_pkg::COEFF_COUNT - 1));
        for (int k = kbw_pkg::COEFF_COUNT - 2; k >= 0; k--)
            acc = ((acc * u + (128'd1 << (kbw_pkg::FRAC_BITS - 1))) >> kbw_pkg::FRAC_BITS)
                  + 128'(tap_q30(k));
        if (acc > (128'd1 << kbw_pkg::FRAC_BITS)) acc = 128'd1 << kbw_pkg::FRAC_BITS;
        r.window_value = acc[kbw_pkg::VALUE_W-1:0];
        r.in_window = 1'b1;
        return r;
    endfunction

    function automatic logic signed [kbw_pkg::POS_W-1:0] pick_position(
        input logic [kbw_pkg::WIDTH_W-1:0] width);
        int unsigned roll;
        logic [31:0] half;
        logic [31:0] mag;
        roll = $urandom_range(99);
        half = 32'(width >> 1);
        if (roll < 15) return $urandom;
        if (roll < 27)
            mag = (half < 2) ? $urandom_range(4) : half - 2 + $urandom_range(4);
        else
            mag = $urandom_range(half);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic void report_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    task automatic send_position(input logic signed [kbw_pkg::POS_W-1:0] pos);
        while (source_gaps_on && $urandom_range(99) < GAP_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.position <= pos;
        do @(posedge i_clk); while (!in_if.ready);
        expected_windows.push_back(window_of(pos, width_now));
    endtask

    task automatic settle_pipeline();
        in_if.valid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_window_width(input logic [kbw_pkg::WIDTH_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= WIDTH_ADDR;
        pwdata <= kbw_pkg::APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        width_now = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== kbw_pkg::APB_DATA_W'(value))
            report_fail($sformatf("window_width readback: expected %0d, got %0d", value, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_width();
        logic [kbw_pkg::POS_W-1:0] spots [11] = '{
            0, 1, -1, 16384, -16384, 32767, -32767, 32768, -32768,
            32'h7FFF_FFFF, 32'h8000_0000
        };
        foreach (spots[i]) send_position(spots[i]);
        settle_pipeline();
    endtask

    task automatic test_width_extremes();
        logic [kbw_pkg::POS_W-1:0] wide_spots [6] = '{
            0, 32'h3FFF_FFFF, -32'sh3FFF_FFFF, 32'h4000_0000, -32'sh4000_0000, 32'h5555_5555
        };
        logic [kbw_pkg::POS_W-1:0] edge_spots [3] = '{0, 1, -1};
        set_window_width(WIDTH_MAX);
        foreach (wide_spots[i]) send_position(wide_spots[i]);
        settle_pipeline();
        set_window_width(kbw_pkg::WIDTH_W'(1));
        foreach (edge_spots[i]) send_position(edge_spots[i]);
        settle_pipeline();
        // zero width puts every position outside
        set_window_width(kbw_pkg::WIDTH_W'(0));
        foreach (edge_spots[i]) send_position(edge_spots[i]);
        settle_pipeline();
    endtask

    task automatic test_random_phases();
        logic [kbw_pkg::WIDTH_W-1:0] width;
        int                          count;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: width = kbw_pkg::WIDTH_W'($urandom_range(32'h7FFF_FFFF, 1));
                1: width = kbw_pkg::WIDTH_W'($urandom_range(4096, 1));
                2: width = kbw_pkg::WIDTH_W'($urandom_range(65536 * 64, 65536));
                default: width = (phase == 3) ? WIDTH_MAX : kbw_pkg::WIDTH_RESET;
            endcase
            set_window_width(width);
            source_gaps_on = (phase != 5);
            sink_gaps_on <= (phase != 5);
            count = (phase == 5) ? 150 : 50;
            repeat (count) send_position(pick_position(width));
            settle_pipeline();
        end
        source_gaps_on = 1'b1;
        sink_gaps_on <= 1'b1;
    endtask

    task automatic test_backpressure();
        set_window_width(kbw_pkg::WIDTH_W'(65536 * 3));
        source_gaps_on = 1'b0;
        sink_gaps_on <= 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
            repeat (150) send_position(pick_position(width_now));
        join
        settle_pipeline();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_windows.size() == 0) begin
                report_fail($sformatf("unexpected word: value %0d in_window %0b",
                                      out_if.window_value, out_if.in_window));
            end else begin
                oldest_window = expected_windows.pop_front();
                if (out_if.window_value !== oldest_window.window_value ||
                    out_if.in_window !== oldest_window.in_window)
                    report_fail($sformatf(
                        "word mismatch: expected value %0d in_window %0b, got %0d in_window %0b",
                        oldest_window.window_value, oldest_window.in_window,
                        out_if.window_value, out_if.in_window));
            end
        end
        out_if.ready <= !sink_hold && !(sink_gaps_on && $urandom_range(99) < GAP_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("kaiser_bessel_window_eval test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.position = '0;
        out_if.ready = 1'b0;
        source_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        sink_hold = 1'b0;
        width_now = kbw_pkg::WIDTH_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_width();
        test_width_extremes();
        test_random_phases();
        test_backpressure();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("kaiser_bessel_window_eval test passed");
        end else begin
            $display("kaiser_bessel_window_eval test failed");
        end
        $finish;
    end

endmodule
